// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Check a property at every rising clock edge, reset included.
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== hw/rtl/psc_pkg.sv =====
package psc_pkg;

   // Pipeline layout: front end, correction, pressure.
   localparam int FRONT_STAGES = 4;
   localparam int CORR_STAGES  = 3;
   localparam int PRESS_STAGES = 5;
   localparam int PIPE_DEPTH   = FRONT_STAGES + CORR_STAGES + PRESS_STAGES;

   localparam int RAW_W   = 24;
   localparam int CAL_W   = 16;
   localparam int OUT_W   = 32;
   localparam int IDX_W   = 3;
   localparam int TEMP_W  = 19;
   localparam int SQ_W    = 35;
   localparam int OFF1_W  = 36;
   localparam int SENS1_W = 35;
   localparam int OFF_W   = 39;
   localparam int SENS_W  = 39;

   // Temperature break points in 0.01 C.
   localparam logic signed [TEMP_W-1:0] TEMP_REF  = 19'sd2000;
   localparam logic signed [TEMP_W-1:0] TEMP_VLOW = -19'sd1500;

   typedef enum logic [IDX_W-1:0] {
      CAL_PRESSURE_SENS  = 3'd0,
      CAL_PRESSURE_OFF   = 3'd1,
      CAL_SENS_TEMP_COEF = 3'd2,
      CAL_OFF_TEMP_COEF  = 3'd3,
      CAL_REF_TEMP       = 3'd4,
      CAL_TEMP_SLOPE     = 3'd5
   } psc_cal_idx_type;

   typedef struct packed {
      logic [CAL_W-1:0] pressure_sensitivity;
      logic [CAL_W-1:0] pressure_offset;
      logic [CAL_W-1:0] sensitivity_temp_coeff;
      logic [CAL_W-1:0] offset_temp_coeff;
      logic [CAL_W-1:0] reference_temperature;
      logic [CAL_W-1:0] temp_slope;
   } psc_cal_type;

   // Front end to correction stages.
   typedef struct packed {
      logic signed [TEMP_W-1:0]  temp_out;
      logic [SQ_W-1:0]           devsq;
      logic [SQ_W-1:0]           lowsq;
      logic                      lowcase;
      logic                      vlow;
      logic signed [OFF1_W-1:0]  off1;
      logic signed [SENS1_W-1:0] sens1;
      logic [RAW_W-1:0]          d1;
   } psc_front_type;

   // Correction stages to pressure stages.
   typedef struct packed {
      logic signed [TEMP_W-1:0] temp_out;
      logic signed [OFF_W-1:0]  off;
      logic signed [SENS_W-1:0] sens;
      logic [RAW_W-1:0]         d1;
   } psc_corr_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] pressure_out;
      logic signed [OUT_W-1:0] temperature_out;
   } psc_result_type;

endpackage

// ===== hw/rtl/psc_pipe_ctrl.sv =====
module psc_pipe_ctrl (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            rsp_tready,
   output logic [psc_pkg::PIPE_DEPTH-1:0]  en,
   output logic                            out_valid
);

   logic [psc_pkg::PIPE_DEPTH-1:0] valid_ff;
   logic [psc_pkg::PIPE_DEPTH-1:0] valid_in;

   // A stage advances when it is empty or the stage after it advances.
   always_comb begin
      en[psc_pkg::PIPE_DEPTH-1] = !valid_ff[psc_pkg::PIPE_DEPTH-1] || rsp_tready;
      for (int k = psc_pkg::PIPE_DEPTH - 2; k >= 0; k--) begin
         en[k] = !valid_ff[k] || en[k+1];
      end
   end

   always_comb begin
      valid_in[0] = en[0] ? req_tvalid : valid_ff[0];
      for (int k = 1; k < psc_pkg::PIPE_DEPTH; k++) begin
         valid_in[k] = en[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign out_valid = valid_ff[psc_pkg::PIPE_DEPTH-1];

endmodule

// ===== hw/rtl/psc_front.sv =====
module psc_front (
   input  logic                               clock,
   input  logic [psc_pkg::FRONT_STAGES-1:0]   en,
   input  psc_pkg::psc_cal_type               cal,
   input  logic [psc_pkg::RAW_W-1:0]          raw_temperature,
   input  logic [psc_pkg::RAW_W-1:0]          raw_pressure,
   output psc_pkg::psc_front_type             front
);

   // Stage 1: temperature difference
   logic signed [24:0]             dt_ff, dt_in;
   logic [psc_pkg::RAW_W-1:0]      d1_s1_ff;

   // Stage 2: products with dT
   logic signed [41:0]             dtc6_ff, dtc6_in;
   logic signed [41:0]             offt_ff, offt_in;
   logic signed [41:0]             senst_ff, senst_in;
   logic signed [49:0]             dtsq_full;
   logic [47:0]                    dtsq_ff, dtsq_in;
   logic [psc_pkg::RAW_W-1:0]      d1_s2_ff;

   // Stage 3: first-order terms
   logic signed [psc_pkg::TEMP_W-1:0]  temp_ff, temp_in;
   logic signed [psc_pkg::TEMP_W-1:0]  dev_ff, dev_in;
   logic signed [psc_pkg::TEMP_W-1:0]  low_ff, low_in;
   logic                               lowcase_ff, lowcase_in;
   logic                               vlow_ff, vlow_in;
   logic [16:0]                        t2_ff, t2_in;
   logic [16:0]                        t2_lo;
   logic [50:0]                        dtsq_x7;
   logic signed [psc_pkg::OFF1_W-1:0]  off1_ff, off1_in;
   logic signed [psc_pkg::SENS1_W-1:0] sens1_ff, sens1_in;
   logic [psc_pkg::RAW_W-1:0]          d1_s3_ff;

   // Stage 4: squares of the temperature deviations
   logic signed [37:0]             devsq_full;
   logic signed [37:0]             lowsq_full;
   psc_pkg::psc_front_type         front_ff, front_in;

   assign dt_in = signed'({1'b0, raw_temperature})
                - signed'({1'b0, cal.reference_temperature, 8'h00});

   always_comb begin
      dtc6_in   = 42'(dt_ff) * 42'(signed'({1'b0, cal.temp_slope}));
      offt_in   = 42'(dt_ff) * 42'(signed'({1'b0, cal.offset_temp_coeff}));
      senst_in  = 42'(dt_ff) * 42'(signed'({1'b0, cal.sensitivity_temp_coeff}));
      dtsq_full = 50'(dt_ff) * 50'(dt_ff);
      dtsq_in   = dtsq_full[47:0];
   end

   always_comb begin
      temp_in    = signed'(dtc6_ff[41:23]) + psc_pkg::TEMP_REF;
      lowcase_in = temp_in < psc_pkg::TEMP_REF;
      vlow_in    = temp_in < psc_pkg::TEMP_VLOW;
      dev_in     = temp_in - psc_pkg::TEMP_REF;
      low_in     = temp_in - psc_pkg::TEMP_VLOW;
      // Cold: 3 * (dT^2 >> 33). Warm: (7 * dT^2) >> 37.
      t2_lo      = {2'b00, dtsq_ff[47:33]} + {1'b0, dtsq_ff[47:33], 1'b0};
      dtsq_x7    = {dtsq_ff, 3'b000} - {3'b000, dtsq_ff};
      t2_in      = lowcase_in ? t2_lo : {3'b000, dtsq_x7[50:37]};
      off1_in    = signed'({4'b0000, cal.pressure_offset, 16'h0000})
                 + 36'(signed'(offt_ff[41:7]));
      sens1_in   = signed'({4'b0000, cal.pressure_sensitivity, 15'h0000})
                 + 35'(signed'(senst_ff[41:8]));
   end

   always_comb begin
      devsq_full       = 38'(dev_ff) * 38'(dev_ff);
      lowsq_full       = 38'(low_ff) * 38'(low_ff);
      front_in.temp_out = temp_ff - signed'({2'b00, t2_ff});
      front_in.devsq   = devsq_full[34:0];
      front_in.lowsq   = lowsq_full[34:0];
      front_in.lowcase = lowcase_ff;
      front_in.vlow    = vlow_ff;
      front_in.off1    = off1_ff;
      front_in.sens1   = sens1_ff;
      front_in.d1      = d1_s3_ff;
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         dt_ff    <= dt_in;
         d1_s1_ff <= raw_pressure;
      end
      if (en[1]) begin
         dtc6_ff  <= dtc6_in;
         offt_ff  <= offt_in;
         senst_ff <= senst_in;
         dtsq_ff  <= dtsq_in;
         d1_s2_ff <= d1_s1_ff;
      end
      if (en[2]) begin
         temp_ff    <= temp_in;
         dev_ff     <= dev_in;
         low_ff     <= low_in;
         lowcase_ff <= lowcase_in;
         vlow_ff    <= vlow_in;
         t2_ff      <= t2_in;
         off1_ff    <= off1_in;
         sens1_ff   <= sens1_in;
         d1_s3_ff   <= d1_s2_ff;
      end
      if (en[3]) begin
         front_ff <= front_in;
      end
   end

   assign front = front_ff;

endmodule

// ===== hw/rtl/psc_corr.sv =====
module psc_corr (
   input  logic                              clock,
   input  logic [psc_pkg::CORR_STAGES-1:0]   en,
   input  psc_pkg::psc_front_type            front,
   output psc_pkg::psc_corr_type             corr
);

   // Stage 5: scaled square terms
   logic [36:0]                        dev_x3, dev_x5;
   logic [37:0]                        low_x7;
   logic [35:0]                        offa_ff, offa_in;
   logic [37:0]                        offb_ff, offb_in;
   logic [33:0]                        sensa_ff, sensa_in;
   logic [36:0]                        sensb_ff, sensb_in;
   logic signed [psc_pkg::TEMP_W-1:0]  temp_s5_ff;
   logic signed [psc_pkg::OFF1_W-1:0]  off1_s5_ff;
   logic signed [psc_pkg::SENS1_W-1:0] sens1_s5_ff;
   logic [psc_pkg::RAW_W-1:0]          d1_s5_ff;

   // Stage 6: OFF2 and SENS2
   logic [37:0]                        off2_ff, off2_in;
   logic [36:0]                        sens2_ff, sens2_in;
   logic signed [psc_pkg::TEMP_W-1:0]  temp_s6_ff;
   logic signed [psc_pkg::OFF1_W-1:0]  off1_s6_ff;
   logic signed [psc_pkg::SENS1_W-1:0] sens1_s6_ff;
   logic [psc_pkg::RAW_W-1:0]          d1_s6_ff;

   // Stage 7: corrected offset and sensitivity
   psc_pkg::psc_corr_type              corr_ff, corr_in;

   always_comb begin
      dev_x3 = {2'b00, front.devsq} + {1'b0, front.devsq, 1'b0};
      dev_x5 = {2'b00, front.devsq} + {front.devsq, 2'b00};
      low_x7 = {front.lowsq, 3'b000} - {3'b000, front.lowsq};
      if (front.lowcase) begin
         offa_in  = dev_x3[36:1];
         sensa_in = dev_x5[36:3];
         offb_in  = front.vlow ? low_x7 : '0;
         sensb_in = front.vlow ? {front.lowsq, 2'b00} : '0;
      end else begin
         offa_in  = {5'b00000, front.devsq[34:4]};
         sensa_in = '0;
         offb_in  = '0;
         sensb_in = '0;
      end
   end

   assign off2_in  = {2'b00, offa_ff} + offb_ff;
   assign sens2_in = {3'b000, sensa_ff} + sensb_ff;

   always_comb begin
      corr_in.temp_out = temp_s6_ff;
      corr_in.off      = 39'(off1_s6_ff) - signed'({1'b0, off2_ff});
      corr_in.sens     = 39'(sens1_s6_ff) - signed'({2'b00, sens2_ff});
      corr_in.d1       = d1_s6_ff;
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         offa_ff     <= offa_in;
         offb_ff     <= offb_in;
         sensa_ff    <= sensa_in;
         sensb_ff    <= sensb_in;
         temp_s5_ff  <= front.temp_out;
         off1_s5_ff  <= front.off1;
         sens1_s5_ff <= front.sens1;
         d1_s5_ff    <= front.d1;
      end
      if (en[1]) begin
         off2_ff     <= off2_in;
         sens2_ff    <= sens2_in;
         temp_s6_ff  <= temp_s5_ff;
         off1_s6_ff  <= off1_s5_ff;
         sens1_s6_ff <= sens1_s5_ff;
         d1_s6_ff    <= d1_s5_ff;
      end
      if (en[2]) begin
         corr_ff <= corr_in;
      end
   end

   assign corr = corr_ff;

endmodule

// ===== hw/rtl/psc_press.sv =====
module psc_press (
   input  logic                               clock,
   input  logic [psc_pkg::PRESS_STAGES-1:0]   en,
   input  psc_pkg::psc_corr_type              corr,
   output psc_pkg::psc_result_type            result
);

   // Stage 8: SENS * D1 as two partial products
   logic signed [18:0]                 sens_hi;
   logic [19:0]                        sens_lo;
   logic signed [43:0]                 ph_ff, ph_in;
   logic [43:0]                        pl_ff, pl_in;
   logic signed [psc_pkg::OFF_W-1:0]   off_s8_ff;
   logic signed [psc_pkg::TEMP_W-1:0]  temp_s8_ff;

   // Stage 9: full product
   logic signed [62:0]                 prod_ff, prod_in;
   logic signed [psc_pkg::OFF_W-1:0]   off_s9_ff;
   logic signed [psc_pkg::TEMP_W-1:0]  temp_s9_ff;

   // Stage 10: product / 2^21, toward zero
   logic signed [62:0]                 prod_biased;
   logic signed [41:0]                 q1_ff, q1_in;
   logic signed [psc_pkg::OFF_W-1:0]   off_s10_ff;
   logic signed [psc_pkg::TEMP_W-1:0]  temp_s10_ff;

   // Stage 11: subtract offset
   logic signed [42:0]                 num_ff, num_in;
   logic signed [psc_pkg::TEMP_W-1:0]  temp_s11_ff;

   // Stage 12: / 2^15 toward zero, output register
   logic signed [42:0]                 num_biased;
   psc_pkg::psc_result_type            result_ff, result_in;

   always_comb begin
      sens_hi = signed'(corr.sens[38:20]);
      sens_lo = corr.sens[19:0];
      ph_in   = 44'(sens_hi) * 44'(signed'({1'b0, corr.d1}));
      pl_in   = 44'(sens_lo) * 44'(corr.d1);
   end

   assign prod_in = (63'(ph_ff) <<< 20) + signed'({19'b0, pl_ff});

   always_comb begin
      prod_biased = prod_ff + signed'({42'b0, {21{prod_ff[62]}}});
      q1_in       = prod_biased[62:21];
   end

   assign num_in = 43'(q1_ff) - 43'(off_s10_ff);

   // The quotient fits 28 bits for every input, so the 32-bit clamp never bites.
   always_comb begin
      num_biased                = num_ff + signed'({28'b0, {15{num_ff[42]}}});
      result_in.pressure_out    = 32'(signed'(num_biased[42:15]));
      result_in.temperature_out = 32'(temp_s11_ff);
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         ph_ff      <= ph_in;
         pl_ff      <= pl_in;
         off_s8_ff  <= corr.off;
         temp_s8_ff <= corr.temp_out;
      end
      if (en[1]) begin
         prod_ff    <= prod_in;
         off_s9_ff  <= off_s8_ff;
         temp_s9_ff <= temp_s8_ff;
      end
      if (en[2]) begin
         q1_ff       <= q1_in;
         off_s10_ff  <= off_s9_ff;
         temp_s10_ff <= temp_s9_ff;
      end
      if (en[3]) begin
         num_ff      <= num_in;
         temp_s11_ff <= temp_s10_ff;
      end
      if (en[4]) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

// ===== hw/rtl/pressure_sensor_compensation_top.sv =====
// Pipeline: 12 register stages. Throughput: one transaction per cycle while
// rsp_tready is high, set by the 12-stage datapath pipeline.
// Each stage advances when empty or when the stage after it advances,
// so bubbles fill while a finished result waits at the output register.
// Reset (synchronous, active high) empties the pipeline and clears all six
// calibration words to zero.
module pressure_sensor_compensation_top (
   input  logic        clock,
   input  logic        reset,
   // Input stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // [23:0] raw_temperature, [47:24] raw_pressure
   // Result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [31:0] temperature_out, [63:32] pressure_out
   // Calibration write port
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);

   localparam int FRONT_LO = 0;
   localparam int CORR_LO  = psc_pkg::FRONT_STAGES;
   localparam int PRESS_LO = psc_pkg::FRONT_STAGES + psc_pkg::CORR_STAGES;

   psc_pkg::psc_cal_type           cal_ff, cal_in;
   logic [psc_pkg::PIPE_DEPTH-1:0] en;
   psc_pkg::psc_front_type         front;
   psc_pkg::psc_corr_type          corr;
   psc_pkg::psc_result_type        result;

   // Calibration words: always ready; writes past the last word are dropped.
   assign csr_ready = 1'b1;

   always_comb begin
      cal_in = cal_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            psc_pkg::CAL_PRESSURE_SENS:  cal_in.pressure_sensitivity   = csr_data;
            psc_pkg::CAL_PRESSURE_OFF:   cal_in.pressure_offset        = csr_data;
            psc_pkg::CAL_SENS_TEMP_COEF: cal_in.sensitivity_temp_coeff = csr_data;
            psc_pkg::CAL_OFF_TEMP_COEF:  cal_in.offset_temp_coeff      = csr_data;
            psc_pkg::CAL_REF_TEMP:       cal_in.reference_temperature  = csr_data;
            psc_pkg::CAL_TEMP_SLOPE:     cal_in.temp_slope             = csr_data;
            default:                     cal_in = cal_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_ff <= '0;
      end else begin
         cal_ff <= cal_in;
      end
   end

   // Valid bits and per-stage advance enables.
   psc_pipe_ctrl u_pipe_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .rsp_tready (rsp_tready),
      .en         (en),
      .out_valid  (rsp_tvalid)
   );

   assign req_tready = en[0];

   // Stages 1-4: dT, products with dT, first-order terms, T2, squares.
   psc_front u_front (
      .clock           (clock),
      .en              (en[FRONT_LO +: psc_pkg::FRONT_STAGES]),
      .cal             (cal_ff),
      .raw_temperature (req_tdata[23:0]),
      .raw_pressure    (req_tdata[47:24]),
      .front           (front)
   );

   // Stages 5-7: second-order OFF2 / SENS2 and the corrected OFF / SENS.
   psc_corr u_corr (
      .clock (clock),
      .en    (en[CORR_LO +: psc_pkg::CORR_STAGES]),
      .front (front),
      .corr  (corr)
   );

   // Stages 8-12: SENS * D1, the two truncating scalings, output register.
   psc_press u_press (
      .clock  (clock),
      .en     (en[PRESS_LO +: psc_pkg::PRESS_STAGES]),
      .corr   (corr),
      .result (result)
   );

   assign rsp_tdata = {result.pressure_out, result.temperature_out};

endmodule

// ===== hw/rtl/psc_checker.sv =====
`include "assert_macros.svh"

module psc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata
);

   logic        rsp_stall;
   logic [13:0] temp_top;
   logic [4:0]  press_top;

   assign rsp_stall = rsp_tvalid && !rsp_tready;
   assign temp_top  = rsp_tdata[31:18];
   assign press_top = rsp_tdata[63:59];

   // Reset empties the pipeline.
   `ASSERT_CLK_ALWAYS(a_reset_empty, reset |=> !rsp_tvalid, "result valid after reset")

   // A stalled result holds.
   `ASSERT_CLK(a_rsp_hold, rsp_stall |=> rsp_tvalid && $stable(rsp_tdata), "stalled result changed")

   // With the output free, the whole pipeline advances and input is taken.
   `ASSERT_CLK(a_no_false_stall, !rsp_stall |-> req_tready, "input stalled with output free")

   // Temperature stays within 19 signed bits.
   `ASSERT_CLK(a_temp_range, rsp_tvalid |-> &temp_top || ~|temp_top, "temperature out of range")

   // Pressure stays within 28 signed bits.
   `ASSERT_CLK(a_press_range, rsp_tvalid |-> &press_top || ~|press_top, "pressure out of range")

endmodule

bind pressure_sensor_compensation_top psc_checker u_psc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== test/tb.sv =====
module tb;
   import psc_pkg::*;

   // Register indexes past the calibration words; writes to them must be dropped.
   localparam logic [IDX_W-1:0] CAL_IDX_SPARE_A = 3'd6;
   localparam logic [IDX_W-1:0] CAL_IDX_SPARE_B = 3'd7;

   localparam longint RAW_MAX = 64'sh00FF_FFFF;
   localparam longint SAT_HI  = 64'sh7FFF_FFFF;
   localparam longint SAT_LO  = -64'sh8000_0000;

   // Typical factory calibration, used where the directed items need realistic numbers.
   localparam psc_cal_type CAL_TYPICAL = '{
      pressure_sensitivity:   16'd46372,
      pressure_offset:        16'd43981,
      sensitivity_temp_coeff: 16'd29059,
      offset_temp_coeff:      16'd27842,
      reference_temperature:  16'd31553,
      temp_slope:             16'd28165
   };
   localparam psc_cal_type CAL_ALL_ZERO = '0;
   localparam psc_cal_type CAL_ALL_ONES = '1;
   localparam logic [RAW_W-1:0] RAW_TYP_PRESSURE = 24'd4311550;

   localparam int ITEMS_PER_PHASE = 100;
   localparam int RANDOM_PHASES   = 8;
   localparam int BURST_ITEMS     = 60;
   localparam int TIMEOUT_TICKS   = 5_000_000;

   logic              clock;
   logic              reset;
   logic              req_tvalid;
   logic              req_tready;
   logic [47:0]       req_tdata;    // [23:0] raw_temperature, [47:24] raw_pressure
   logic              rsp_tvalid;
   logic              rsp_tready;
   logic [63:0]       rsp_tdata;    // [31:0] temperature_out, [63:32] pressure_out
   logic              csr_valid;
   logic              csr_ready;
   logic [IDX_W-1:0]  csr_index;
   logic [CAL_W-1:0]  csr_data;

   // Calibration words as the block should hold them, and results still owed by it.
   psc_cal_type       cal_words;
   psc_result_type    compensated_due[$];
   int                bad_results;
   bit                no_gaps;

   pressure_sensor_compensation_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Compensate one reading pair: first-order terms, then the second-order
   // correction picked by the first-order temperature. Shifts floor, divides
   // truncate toward zero, squares are 64 bits wide.
   function automatic psc_result_type compensate(input logic [RAW_W-1:0] raw_t,
                                                 input logic [RAW_W-1:0] raw_p,
                                                 input psc_cal_type c);
      longint k_sens, k_off, k_tcs, k_tco, k_tref, k_slope;
      longint d2, d1, dt, temp, dev, cold, t2, off2, sens2, off, sens, p;
      psc_result_type r;
      k_sens  = c.pressure_sensitivity;
      k_off   = c.pressure_offset;
      k_tcs   = c.sensitivity_temp_coeff;
      k_tco   = c.offset_temp_coeff;
      k_tref  = c.reference_temperature;
      k_slope = c.temp_slope;
      d2 = raw_t;
      d1 = raw_p;

      dt   = d2 - k_tref * 256;
      temp = 2000 + ((dt * k_slope) >>> 23);
      dev  = temp - 2000;
      if (temp < TEMP_REF) begin
         t2    = 3 * ((dt * dt) >>> 33);
         off2  = 3 * (dev * dev) / 2;
         sens2 = 5 * (dev * dev) / 8;
         if (temp < TEMP_VLOW) begin
            cold  = temp + 1500;
            off2  = off2 + 7 * (cold * cold);
            sens2 = sens2 + 4 * (cold * cold);
         end
      end else begin
         t2    = (7 * dt * dt) >>> 37;
         off2  = (dev * dev) / 16;
         sens2 = 0;
      end

      off  = k_off * 65536 + ((k_tco * dt) >>> 7);
      sens = k_sens * 32768 + ((k_tcs * dt) >>> 8);
      temp = temp - t2;
      off  = off - off2;
      sens = sens - sens2;

      p = ((sens * d1) / 2097152 - off) / 32768;
      if (p > SAT_HI) p = SAT_HI;
      if (p < SAT_LO) p = SAT_LO;
      if (temp > SAT_HI) temp = SAT_HI;
      if (temp < SAT_LO) temp = SAT_LO;
      r.temperature_out = 32'(temp);
      r.pressure_out    = 32'(p);
      return r;
   endfunction

   // Mostly no gap, often a short one, now and then a long one.
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Drive one reading pair, hold it until the req transaction completes,
   // record the result it owes, then idle the input for a random gap unless no_gaps is set.
   task automatic send_reading(input logic [RAW_W-1:0] raw_t, input logic [RAW_W-1:0] raw_p);
      int unsigned gap;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {raw_p, raw_t};
      do @(posedge clock); while (!req_tready);
      compensated_due.push_back(compensate(raw_t, raw_p, cal_words));
      gap = no_gaps ? 0 : pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   // Half the items sit around the reference temperature so every
   // correction branch gets exercised; the rest span the full raw range.
   task automatic send_random_reading();
      longint center, spot;
      if ($urandom_range(0, 1) == 0) begin
         center = cal_words.reference_temperature;
         center = center * 256;
         spot   = $urandom_range(0, 4_000_000);
         spot   = center + spot - 2_000_000;
         if (spot < 0) spot = 0;
         if (spot > RAW_MAX) spot = RAW_MAX;
         send_reading(24'(spot), 24'($urandom_range(2_000_000, 6_000_000)));
      end else begin
         send_reading(24'($urandom), 24'($urandom));
      end
   endtask

   // Stop the input and hold until every owed result has come back.
   task automatic wait_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (compensated_due.size() != 0) @(posedge clock);
   endtask

   // One csr transaction; indexes past the last word leave the model untouched.
   task automatic write_cal(input logic [IDX_W-1:0] idx, input logic [CAL_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CAL_PRESSURE_SENS:  cal_words.pressure_sensitivity   = value;
         CAL_PRESSURE_OFF:   cal_words.pressure_offset        = value;
         CAL_SENS_TEMP_COEF: cal_words.sensitivity_temp_coeff = value;
         CAL_OFF_TEMP_COEF:  cal_words.offset_temp_coeff      = value;
         CAL_REF_TEMP:       cal_words.reference_temperature  = value;
         CAL_TEMP_SLOPE:     cal_words.temp_slope             = value;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Drain the pipeline first: calibration only changes while the block is idle.
   task automatic load_cal(input psc_cal_type c);
      wait_idle();
      write_cal(CAL_PRESSURE_SENS,  c.pressure_sensitivity);
      write_cal(CAL_PRESSURE_OFF,   c.pressure_offset);
      write_cal(CAL_SENS_TEMP_COEF, c.sensitivity_temp_coeff);
      write_cal(CAL_OFF_TEMP_COEF,  c.offset_temp_coeff);
      write_cal(CAL_REF_TEMP,       c.reference_temperature);
      write_cal(CAL_TEMP_SLOPE,     c.temp_slope);
   endtask

   // Calibration words are all zero out of reset.
   task automatic test_reset_values();
      send_reading(24'd8387300, RAW_TYP_PRESSURE);
      send_reading(24'd0, 24'hFF_FFFF);
      send_reading(24'hFF_FFFF, 24'd0);
   endtask

   // Load every word, then hit the spare indexes; those writes must not land anywhere.
   task automatic test_cal_port();
      load_cal(CAL_TYPICAL);
      write_cal(CAL_IDX_SPARE_A, 16'($urandom));
      write_cal(CAL_IDX_SPARE_B, 16'hFFFF);
      send_reading(24'd8387300, RAW_TYP_PRESSURE);
      send_reading(24'd8569150, 24'd4400000);
   endtask

   // Put the first-order temperature right at the 20 C and -15 C boundaries
   // and just below them, plus far hot and far cold.
   task automatic test_temperature_regions();
      longint center, slope, span, k_low;
      load_cal(CAL_TYPICAL);
      center = cal_words.reference_temperature;
      center = center * 256;
      slope  = cal_words.temp_slope;
      span   = TEMP_REF - TEMP_VLOW;
      k_low  = (span <<< 23) / slope;
      send_reading(24'(center), RAW_TYP_PRESSURE);
      send_reading(24'(center - 1), RAW_TYP_PRESSURE);
      send_reading(24'(center - k_low), RAW_TYP_PRESSURE);
      send_reading(24'(center - k_low - 1), RAW_TYP_PRESSURE);
      send_reading(24'(center + 500_000), RAW_TYP_PRESSURE);
      send_reading(24'd0, RAW_TYP_PRESSURE);
   endtask

   // Field extremes under extreme and typical calibration.
   task automatic test_field_extremes();
      load_cal(CAL_ALL_ONES);
      send_reading(24'd0, 24'd0);
      send_reading(24'hFF_FFFF, 24'hFF_FFFF);
      send_reading(24'd0, 24'hFF_FFFF);
      send_reading(24'hFF_FFFF, 24'd0);
      load_cal(CAL_ALL_ZERO);
      send_reading(24'hFF_FFFF, 24'hFF_FFFF);
      load_cal(CAL_TYPICAL);
      send_reading(24'hAA_AAAA, 24'h55_5555);
      send_reading(24'h55_5555, 24'hAA_AAAA);
   endtask

   // Full rate on both sides: one transaction per cycle with no stalls.
   task automatic test_back_to_back();
      load_cal(CAL_TYPICAL);
      no_gaps = 1'b1;
      repeat (BURST_ITEMS) send_random_reading();
      wait_idle();
      no_gaps = 1'b0;
   endtask

   // Several calibration settings, extremes first, then typical, then random and near-typical ones.
   task automatic test_random_phases();
      psc_cal_type c;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0:       c = CAL_ALL_ONES;
            1:       c = CAL_ALL_ZERO;
            2:       c = CAL_TYPICAL;
            default: begin
               if (phase % 2 == 0) begin
                  c = {16'($urandom), 16'($urandom), 16'($urandom),
                       16'($urandom), 16'($urandom), 16'($urandom)};
               end else begin
                  c = CAL_TYPICAL ^ {6{4'h0, 12'($urandom)}};
               end
            end
         endcase
         load_cal(c);
         repeat (ITEMS_PER_PHASE) send_random_reading();
      end
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_valid  = 1'b0;
      csr_index  = '0;
      csr_data   = '0;
      cal_words  = CAL_ALL_ZERO;
      no_gaps    = 1'b0;
      // Hold reset, then release it on a falling edge.
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      test_reset_values();
      test_cal_port();
      test_temperature_regions();
      test_field_extremes();
      test_back_to_back();
      test_random_phases();

      // Drain, then give the pipeline time to show any stray result.
      wait_idle();
      repeat (PIPE_DEPTH + 8) @(posedge clock);
      if (bad_results == 0) begin
         $display("pressure_sensor_compensation_top: match");
      end else begin
         $display("pressure_sensor_compensation_top: mismatch");
      end
      $finish;
   end

   // Result side back-pressure: random stalls, dropped entirely during bursts.
   initial begin : rsp_stall_gen
      int unsigned stall_left;
      stall_left = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (no_gaps) begin
            stall_left = 0;
            rsp_tready <= 1'b1;
         end else if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
            if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
         end
      end
   end

   // Compare each rsp transaction against the oldest owed result, field by field.
   initial bad_results = 0;
   always @(posedge clock) begin : check_results
      psc_result_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (compensated_due.size() == 0) begin
            $display("%0t: unexpected result, expected none, got temperature %0d pressure %0d",
                     $time, got.temperature_out, got.pressure_out);
            bad_results++;
         end else begin
            want = compensated_due.pop_front();
            if (got.temperature_out !== want.temperature_out) begin
               $display("%0t: temperature_out expected %0d, got %0d",
                        $time, want.temperature_out, got.temperature_out);
               bad_results++;
            end
            if (got.pressure_out !== want.pressure_out) begin
               $display("%0t: pressure_out expected %0d, got %0d",
                        $time, want.pressure_out, got.pressure_out);
               bad_results++;
            end
         end
      end
   end

   // Hard stop well beyond the slowest legal run.
   initial begin
      #(TIMEOUT_TICKS);
      $display("pressure_sensor_compensation_top: mismatch");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/psc_pkg.sv
hw/rtl/psc_pipe_ctrl.sv
hw/rtl/psc_front.sv
hw/rtl/psc_corr.sv
hw/rtl/psc_press.sv
hw/rtl/pressure_sensor_compensation_top.sv
hw/rtl/psc_checker.sv
test/tb.sv
